/* rtl/core/cetvs_pkg.sv */
// ----------------------------------------------------------------------------
// Cache entry table package
// Shared request/result types and command codes for the slot table.
// ----------------------------------------------------------------------------
package cetvs_pkg;

  // Command codes of a request.
  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_LOOKUP  = 3'd1,
    CMD_PIN_ONE = 3'd2,
    CMD_PIN_GRP = 3'd3,
    CMD_VICTIM  = 3'd4,
    CMD_RELEASE = 3'd5,
    CMD_NOP6    = 3'd6,
    CMD_NOP7    = 3'd7
  } cmd_e;

  localparam int unsigned CfgWidth  = 10;
  localparam int unsigned SlotWidth = 9;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] group_id;
    logic [31:0] item_index;
    logic        persistent_flag;
    logic        pin_flag;
    logic [31:0] group_order;
    logic        ignore_order;
    logic [8:0]  release_slot;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [8:0] slot;
  } rsp_t;

  // Per-slot flags.
  typedef struct packed {
    logic used;
    logic persistent;
    logic pinned;
  } flags_t;

endpackage

/* rtl/core/cache_entry_table_with_victim_select.sv */
// ----------------------------------------------------------------------------
// Cache entry table with victim select
// Slot table with next-fit allocation, key lookup, pinning and eviction choice.
// ----------------------------------------------------------------------------
// Every request except release and unknown codes scans all POOL_DEPTH slots,
// one slot per cycle; release and unknown codes skip the scan. The per-slot
// flags live in a ring of cells that rotates one position per scan cycle, so
// slot s sits at the head of the ring when slot s is checked; the wide fields
// sit in a memory read at the scanned slot. After reset no clearing pass is
// needed.
module cache_entry_table_with_victim_select #(
  parameter int unsigned POOL_DEPTH = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [9:0]          cfg_wdata_i,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  cetvs_pkg::req_t     req_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output cetvs_pkg::rsp_t     rsp_o
);

  localparam int unsigned IdxW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(POOL_DEPTH + 1);
  localparam int unsigned SlotW = cetvs_pkg::SlotWidth;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_LAST = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Configuration register and request capture.
  logic [9:0] cfg_q;
  cetvs_pkg::req_t req_q;
  logic [CntW-1:0] count;
  always_comb begin
    if (cfg_q == '0 || {22'd0, cfg_q} > 32'(POOL_DEPTH)) begin
      count = CntW'(POOL_DEPTH);
    end else begin
      count = CntW'(cfg_q);
    end
  end

  // Wide slot fields in memory.
  logic [31:0] mem_group [POOL_DEPTH];
  logic [31:0] mem_item  [POOL_DEPTH];
  logic [31:0] mem_order [POOL_DEPTH];
  logic [31:0] mem_stamp [POOL_DEPTH];
  logic [31:0] rd_group_q, rd_item_q, rd_order_q, rd_stamp_q;
  logic        wr_en;
  logic [IdxW-1:0] wr_idx;
  logic [IdxW-1:0] rd_idx;

  // Scan counters: rd_idx addresses memory, chk_q is the registered copy of scan_q.
  logic [IdxW-1:0] scan_q, chk_q;
  logic            chk_valid_q;

  // Ring of flag cells.
  cetvs_pkg::flags_t ring [POOL_DEPTH];
  cetvs_pkg::flags_t head;
  logic shift;
  logic [POOL_DEPTH-1:0] load;
  cetvs_pkg::flags_t load_flags;
  logic [IdxW-1:0] rel_idx;
  logic rel_ok;

  for (genvar g = 0; g < POOL_DEPTH; g++) begin : g_cell
    cetvs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .shift_i      (shift),
      .load_i       (load[g]),
      .load_flags_i (load_flags),
      .prev_i       (ring[(g + 1) % POOL_DEPTH]),
      .flags_o      (ring[g])
    );
  end

  // The head cell holds the flags of the slot under check.
  assign head = ring[0];

  // Scan bookkeeping and results.
  logic [IdxW-1:0] start_q;
  logic [31:0]     stamp_q;
  logic            best_ok_q;
  logic [IdxW-1:0] best_q;
  logic [31:0]     best_order_q, best_age_q;
  cetvs_pkg::flags_t best_flags_q;
  logic [IdxW-1:0] alloc_q;
  logic            alloc_ok_q;
  logic            alloc_wrap_q;
  logic            rsp_valid_q;
  cetvs_pkg::rsp_t rsp_q, rsp_d;

  logic [IdxW-1:0] first;
  assign first = ({{(32-CntW){1'b0}}, CntW'(start_q)} < {{(32-CntW){1'b0}}, count})
                 ? start_q : '0;
  assign rd_idx = scan_q;

  // Evaluation of the slot under check.
  logic match_key, match_grp, cand;
  logic [31:0] age;
  logic better;
  logic in_range;
  logic pre_start;
  assign match_grp = head.used && (rd_group_q == req_q.group_id);
  assign match_key = match_grp && (rd_item_q == req_q.item_index);
  assign age = stamp_q - rd_stamp_q;
  assign cand = head.used && !head.persistent && !head.pinned &&
                (rd_group_q != req_q.group_id);
  assign in_range = ({{(32-IdxW){1'b0}}, chk_q} < {{(32-CntW){1'b0}}, count});
  assign pre_start = (chk_q < first);

  always_comb begin
    better = 1'b0;
    case (req_q.cmd)
      cetvs_pkg::CMD_LOOKUP, cetvs_pkg::CMD_PIN_ONE: begin
        better = match_key && (!best_ok_q || age > best_age_q);
      end
      cetvs_pkg::CMD_VICTIM: begin
        better = cand && (!best_ok_q || rd_order_q < best_order_q ||
                 (rd_order_q == best_order_q && age < best_age_q));
      end
      default: better = 1'b0;
    endcase
  end

  // Free slot for allocate: the first free at or past the start wins, else
  // the first free before it.
  logic alloc_take;
  assign alloc_take = !head.used && in_range &&
                      (!alloc_ok_q || (alloc_wrap_q && !pre_start));

  // Control.
  logic scan_cmd;
  assign scan_cmd = (req_i.cmd == cetvs_pkg::CMD_ALLOC)  ||
                    (req_i.cmd == cetvs_pkg::CMD_LOOKUP) ||
                    (req_i.cmd == cetvs_pkg::CMD_PIN_ONE) ||
                    (req_i.cmd == cetvs_pkg::CMD_PIN_GRP) ||
                    (req_i.cmd == cetvs_pkg::CMD_VICTIM);
  logic req_fire;
  assign req_ready_o = (state_q == ST_IDLE) && !rsp_valid_q;
  assign req_fire = req_valid_i && req_ready_o;
  assign shift = chk_valid_q;
  assign rel_idx = IdxW'(req_q.release_slot);
  assign rel_ok = ({{(32-SlotW){1'b0}}, req_q.release_slot} < 32'(POOL_DEPTH));

  // Writes into the ring: group pin updates ride the head cell during the scan;
  // allocate, single pin and release load one fixed cell at the end.
  always_comb begin
    load = '0;
    load_flags = ring[0];
    wr_en = 1'b0;
    wr_idx = alloc_q;
    if (state_q == ST_DONE) begin
      if (req_q.cmd == cetvs_pkg::CMD_ALLOC && alloc_ok_q) begin
        load[alloc_q] = 1'b1;
        load_flags = '{used: 1'b1, persistent: req_q.persistent_flag,
                       pinned: req_q.pin_flag};
        wr_en = 1'b1;
      end else if (req_q.cmd == cetvs_pkg::CMD_PIN_ONE && best_ok_q) begin
        load[best_q] = 1'b1;
        load_flags = best_flags_q;
        load_flags.pinned = req_q.pin_flag;
      end else if (req_q.cmd == cetvs_pkg::CMD_RELEASE && rel_ok) begin
        load[rel_idx] = 1'b1;
        load_flags = '0;
      end
    end else if (chk_valid_q && req_q.cmd == cetvs_pkg::CMD_PIN_GRP && match_grp) begin
      // The head cell moves to the tail on this shift.
      load[POOL_DEPTH-1] = 1'b1;
      load_flags = head;
      load_flags.pinned = req_q.pin_flag;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (req_fire) state_d = scan_cmd ? ST_SCAN : ST_DONE;
      ST_SCAN: if (scan_q == IdxW'(POOL_DEPTH - 1)) state_d = ST_LAST;
      ST_LAST: state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Result of the finished request.
  always_comb begin
    rsp_d = '0;
    case (req_q.cmd)
      cetvs_pkg::CMD_ALLOC: begin
        if (alloc_ok_q) begin
          rsp_d.found = 1'b1;
          rsp_d.slot  = SlotW'(alloc_q);
        end
      end
      cetvs_pkg::CMD_LOOKUP, cetvs_pkg::CMD_VICTIM: begin
        rsp_d.found = best_ok_q;
        rsp_d.slot  = best_ok_q ? SlotW'(best_q) : '0;
      end
      default: rsp_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_group[wr_idx] <= req_q.group_id;
      mem_item[wr_idx]  <= req_q.item_index;
      mem_order[wr_idx] <= req_q.group_order;
      mem_stamp[wr_idx] <= stamp_q;
    end
    rd_group_q <= mem_group[rd_idx];
    rd_item_q  <= mem_item[rd_idx];
    rd_order_q <= mem_order[rd_idx];
    rd_stamp_q <= mem_stamp[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cfg_q        <= 10'd512;
      scan_q       <= '0;
      chk_q        <= '0;
      chk_valid_q  <= 1'b0;
      start_q      <= '0;
      stamp_q      <= '0;
      best_ok_q    <= 1'b0;
      best_q       <= '0;
      best_order_q <= '0;
      best_age_q   <= '0;
      best_flags_q <= '0;
      alloc_q      <= '0;
      alloc_ok_q   <= 1'b0;
      alloc_wrap_q <= 1'b0;
      rsp_valid_q  <= 1'b0;
      rsp_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (rsp_valid_q && rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      chk_valid_q <= (state_q == ST_SCAN);
      chk_q       <= scan_q;
      if (req_fire) begin
        scan_q       <= '0;
        best_ok_q    <= 1'b0;
        alloc_ok_q   <= 1'b0;
        alloc_wrap_q <= 1'b0;
      end
      if (state_q == ST_SCAN) begin
        scan_q <= scan_q + 1'b1;
      end
      if (chk_valid_q) begin
        if (better) begin
          best_ok_q    <= 1'b1;
          best_q       <= chk_q;
          best_order_q <= rd_order_q;
          best_age_q   <= age;
          best_flags_q <= head;
        end
        if (alloc_take) begin
          alloc_ok_q   <= 1'b1;
          alloc_q      <= chk_q;
          alloc_wrap_q <= pre_start;
        end
      end
      if (state_q == ST_DONE) begin
        rsp_valid_q <= 1'b1;
        rsp_q       <= rsp_d;
        if (req_q.cmd == cetvs_pkg::CMD_ALLOC && alloc_ok_q) begin
          stamp_q <= stamp_q + 32'd1;
          if ({{(32-IdxW){1'b0}}, alloc_q} + 32'd1 >=
              {{(32-CntW){1'b0}}, count}) begin
            start_q <= '0;
          end else begin
            start_q <= alloc_q + 1'b1;
          end
        end
      end
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o = rsp_q;

endmodule

/* rtl/core/cetvs_cell.sv */
// ----------------------------------------------------------------------------
// Cache entry table cell
// Holds the flags of one slot; the flags rotate through the chain of cells.
// ----------------------------------------------------------------------------
module cetvs_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  logic               load_i,
  input  cetvs_pkg::flags_t  load_flags_i,
  input  cetvs_pkg::flags_t  prev_i,
  output cetvs_pkg::flags_t  flags_o
);

  cetvs_pkg::flags_t flags_q, flags_d;

  // Take the neighbor's flags while shifting, or a new value on load.
  always_comb begin
    flags_d = flags_q;
    if (shift_i) begin
      flags_d = prev_i;
    end
    if (load_i) begin
      flags_d = load_flags_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  assign flags_o = flags_q;

endmodule

/* rtl/core/cetvs_checker.sv */
// ----------------------------------------------------------------------------
// Cache entry table port checker
// Checks port behavior of the slot table over time.
// ----------------------------------------------------------------------------
module cetvs_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            req_valid_i,
  input logic            req_ready_o,
  input logic            rsp_valid_o,
  input logic            rsp_ready_i,
  input cetvs_pkg::rsp_t rsp_o
);

  // A result that is not found reports slot zero.
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.found |-> rsp_o.slot == '0)
    else $error("slot not zero on miss");

  // A stalled result holds.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("result changed while stalled");

  // One request at a time: no new request while a result waits.
  a_one_at_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !req_ready_o)
    else $error("request taken while result pending");

  // An accepted request is not followed by another in the next cycle.
  a_no_b2b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o)
    else $error("back to back requests");

endmodule

bind cache_entry_table_with_victim_select cetvs_checker u_cetvs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_valid_i),
  .req_ready_o (req_ready_o),
  .rsp_valid_o (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i),
  .rsp_o       (rsp_o)
);

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache entry table testbench
// Drives slot table requests through the valid/ready channels under several
// table sizes and idle patterns, predicts every result from its own copy of
// the table and compares each result in order of acceptance.
// ----------------------------------------------------------------------------
module tb;

  // Slot table predictor and store of pending results.
  class slot_table_scoreboard;
    logic        used [512];
    logic        persistent [512];
    logic        pinned [512];
    logic [31:0] grp [512];
    logic [31:0] itm [512];
    logic [31:0] order [512];
    logic [31:0] stamp [512];
    logic [8:0]  next_start;
    logic [31:0] stamp_ctr;
    logic [9:0]  size_reg;
    cetvs_pkg::rsp_t pending_rsp [$];
    int          errors;

    function void clear();
      for (int s = 0; s < 512; s++) begin
        used[s] = 0; persistent[s] = 0; pinned[s] = 0;
        grp[s] = '0; itm[s] = '0; order[s] = '0; stamp[s] = '0;
      end
      next_start = '0;
      stamp_ctr = '0;
      size_reg = 10'd512;
      errors = 0;
    endfunction

    // Oldest in-use entry holding the key, or -1.
    function int oldest_match(logic [31:0] g, logic [31:0] it);
      int best;
      logic [31:0] best_age;
      logic [31:0] age;
      best = -1;
      best_age = '0;
      for (int s = 0; s < 512; s++) begin
        if (used[s] && grp[s] == g && itm[s] == it) begin
          age = stamp_ctr - stamp[s];
          if (best < 0 || age > best_age) begin
            best = s;
            best_age = age;
          end
        end
      end
      return best;
    endfunction

    function void note_request(cetvs_pkg::req_t r);
      cetvs_pkg::rsp_t res;
      int unsigned cnt;
      int unsigned i;
      int          hit;
      logic [31:0] best_order;
      logic [31:0] best_age;
      logic [31:0] age;
      res = '0;
      cnt = (size_reg == 0 || size_reg > 512) ? 512 : size_reg;
      case (cetvs_pkg::cmd_e'(r.cmd))
        cetvs_pkg::CMD_ALLOC: begin
          i = (next_start < cnt) ? next_start : 0;
          for (int k = 0; k < cnt; k++) begin
            if (!used[i]) begin
              used[i] = 1;
              persistent[i] = r.persistent_flag;
              pinned[i] = r.pin_flag;
              grp[i] = r.group_id;
              itm[i] = r.item_index;
              order[i] = r.group_order;
              stamp[i] = stamp_ctr;
              stamp_ctr = stamp_ctr + 1;
              res.found = 1;
              res.slot = i[8:0];
              next_start = (i + 1 >= cnt) ? 9'd0 : 9'(i + 1);
              break;
            end
            i = (i + 1 >= cnt) ? 0 : i + 1;
          end
        end
        cetvs_pkg::CMD_LOOKUP, cetvs_pkg::CMD_PIN_ONE: begin
          hit = oldest_match(r.group_id, r.item_index);
          if (hit >= 0) begin
            if (r.cmd == cetvs_pkg::CMD_LOOKUP) begin
              res.found = 1;
              res.slot = hit[8:0];
            end else begin
              pinned[hit] = r.pin_flag;
            end
          end
        end
        cetvs_pkg::CMD_PIN_GRP: begin
          for (int s = 0; s < 512; s++)
            if (used[s] && grp[s] == r.group_id) pinned[s] = r.pin_flag;
        end
        cetvs_pkg::CMD_VICTIM: begin
          best_order = '0;
          best_age = '0;
          for (int s = 0; s < 512; s++) begin
            if (used[s] && !persistent[s] && !pinned[s] && grp[s] != r.group_id) begin
              age = stamp_ctr - stamp[s];
              if (!res.found || order[s] < best_order ||
                  (order[s] == best_order && age < best_age)) begin
                res.found = 1;
                res.slot = s[8:0];
                best_order = order[s];
                best_age = age;
              end
            end
          end
        end
        cetvs_pkg::CMD_RELEASE: begin
          used[r.release_slot] = 0;
          persistent[r.release_slot] = 0;
          pinned[r.release_slot] = 0;
        end
        default: ;
      endcase
      pending_rsp.push_back(res);
    endfunction

    function void check_response(cetvs_pkg::rsp_t got);
      cetvs_pkg::rsp_t want;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result found=%0d slot=%0d", $time, got.found, got.slot);
        errors++;
        return;
      end
      want = pending_rsp.pop_front();
      if (got.found !== want.found) begin
        $display("%0t: found mismatch expected %0d actual %0d", $time, want.found, got.found);
        errors++;
      end
      if (got.slot !== want.slot) begin
        $display("%0t: slot mismatch expected %0d actual %0d", $time, want.slot, got.slot);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [9:0] cfg_wdata_i = '0;
  logic req_valid_i = 0;
  logic req_ready_o;
  cetvs_pkg::req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 0;
  cetvs_pkg::rsp_t rsp_o;

  slot_table_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic start_hold = 0;
  int hold_left = 0;
  longint cycle_count = 0;
  logic [31:0] group_pool [8];

  cache_entry_table_with_victim_select u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .req_valid_i, .req_ready_o, .req_i,
    .rsp_valid_o, .rsp_ready_i, .rsp_o
  );

  always #5 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 4000000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Result side: check accepted results and pick the next ready value.
  always @(posedge clk_i) begin
    if (rsp_valid_o && rsp_ready_i) sb.check_response(rsp_o);
    if (start_hold) hold_left = 3000;
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_ready_i <= 0;
    end else begin
      rsp_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one request and wait until it is accepted.
  task automatic send_request(cetvs_pkg::req_t r);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid_i <= 0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid_i <= 1;
    req_i <= r;
    do @(posedge clk_i); while (!req_ready_o);
    sb.note_request(r);
  endtask

  // Stop offering and wait until every pending result has come.
  task automatic drain();
    req_valid_i <= 0;
    @(posedge clk_i);
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_size(logic [9:0] v);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.size_reg = v;
    @(posedge clk_i);
  endtask

  function automatic cetvs_pkg::req_t make_req(cetvs_pkg::cmd_e c, logic [31:0] g,
                                               logic [31:0] it, logic pers, logic pin,
                                               logic [31:0] ord, logic ign,
                                               logic [8:0] rel);
    cetvs_pkg::req_t r;
    r.cmd = c; r.group_id = g; r.item_index = it; r.persistent_flag = pers;
    r.pin_flag = pin; r.group_order = ord; r.ignore_order = ign; r.release_slot = rel;
    return r;
  endfunction

  // Random request, mostly keys from a small pool so lookups and pins hit.
  function automatic cetvs_pkg::req_t random_req(int unsigned cnt);
    cetvs_pkg::req_t r;
    logic [127:0] raw;
    int unsigned w;
    raw = {$urandom, $urandom, $urandom, $urandom};
    r = raw[$bits(cetvs_pkg::req_t)-1:0];
    w = $urandom_range(99);
    if (w < 30) r.cmd = cetvs_pkg::CMD_ALLOC;
    else if (w < 45) r.cmd = cetvs_pkg::CMD_LOOKUP;
    else if (w < 55) r.cmd = cetvs_pkg::CMD_PIN_ONE;
    else if (w < 63) r.cmd = cetvs_pkg::CMD_PIN_GRP;
    else if (w < 78) r.cmd = cetvs_pkg::CMD_VICTIM;
    else if (w < 95) r.cmd = cetvs_pkg::CMD_RELEASE;
    else r.cmd = $urandom_range(1) ? cetvs_pkg::CMD_NOP6 : cetvs_pkg::CMD_NOP7;
    if ($urandom_range(9) != 0) r.group_id = group_pool[$urandom_range(7)];
    if ($urandom_range(9) != 0) r.item_index = $urandom_range(3);
    r.persistent_flag = ($urandom_range(4) == 0);
    if ($urandom_range(3) != 0) r.group_order = $urandom_range(7);
    if ($urandom_range(4) != 0) r.release_slot = 9'($urandom_range(cnt - 1));
    return r;
  endfunction

  initial begin
    logic [9:0] sizes [6];
    int unsigned cnt;
    sb = new();
    sb.clear();
    sizes = '{10'd16, 10'd512, 10'd3, 10'd1023, 10'd0, 10'd64};
    for (int g = 0; g < 8; g++) group_pool[g] = (g == 7) ? 32'hFFFF_FFFF : g;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    repeat (2) @(posedge clk_i);

    // Directed part at the reset size of 512.
    send_request(make_req(cetvs_pkg::CMD_ALLOC, 32'd0, 32'd0, 0, 0, 32'd5, 0, 9'd0));
    send_request(make_req(cetvs_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1,
                          32'hFFFF_FFFF, 1, 9'h1FF));
    send_request(make_req(cetvs_pkg::CMD_ALLOC, 32'd1, 32'd2, 0, 0, 32'd5, 0, 9'd0));
    send_request(make_req(cetvs_pkg::CMD_ALLOC, 32'd1, 32'd2, 0, 0, 32'd9, 0, 9'd0));
    send_request(make_req(cetvs_pkg::CMD_LOOKUP, 32'd1, 32'd2, 0, 0, 32'd0, 0, 9'd0));
    send_request(make_req(cetvs_pkg::CMD_LOOKUP, 32'd7, 32'd2, 0, 0, 32'd0, 0, 9'd0));
    send_request(make_req(cetvs_pkg::CMD_VICTIM, 32'd3, 32'd0, 0, 0, 32'd0, 0, 9'd0));
    send_request(make_req(cetvs_pkg::CMD_VICTIM, 32'd3, 32'd0, 0, 0, 32'd0, 1, 9'd0));
    send_request(make_req(cetvs_pkg::CMD_VICTIM, 32'd1, 32'd0, 0, 0, 32'd0, 0, 9'd0));
    send_request(make_req(cetvs_pkg::CMD_PIN_ONE, 32'd1, 32'd2, 0, 1, 32'd0, 0, 9'd0));
    send_request(make_req(cetvs_pkg::CMD_PIN_ONE, 32'd1, 32'd5, 0, 1, 32'd0, 0, 9'd0));
    send_request(make_req(cetvs_pkg::CMD_PIN_GRP, 32'd1, 32'd0, 0, 1, 32'd0, 0, 9'd0));
    send_request(make_req(cetvs_pkg::CMD_VICTIM, 32'd9, 32'd0, 0, 0, 32'd0, 0, 9'd0));
    send_request(make_req(cetvs_pkg::CMD_PIN_GRP, 32'd1, 32'd0, 0, 0, 32'd0, 0, 9'd0));
    send_request(make_req(cetvs_pkg::CMD_RELEASE, 32'd0, 32'd0, 0, 0, 32'd0, 0, 9'd2));
    send_request(make_req(cetvs_pkg::CMD_RELEASE, 32'd0, 32'd0, 0, 0, 32'd0, 0, 9'd2));
    send_request(make_req(cetvs_pkg::CMD_RELEASE, 32'd0, 32'd0, 0, 0, 32'd0, 0, 9'h1FF));
    send_request(make_req(cetvs_pkg::CMD_NOP6, 32'd0, 32'd0, 0, 0, 32'd0, 0, 9'd0));
    send_request(make_req(cetvs_pkg::CMD_NOP7, 32'd0, 32'd0, 0, 0, 32'd0, 0, 9'd0));
    drain();

    // Two slots: pointer beyond the count, table full, last checked slot free.
    write_size(10'd2);
    send_request(make_req(cetvs_pkg::CMD_ALLOC, 32'd4, 32'd1, 0, 0, 32'd1, 0, 9'd0));
    send_request(make_req(cetvs_pkg::CMD_RELEASE, 32'd0, 32'd0, 0, 0, 32'd0, 0, 9'd1));
    send_request(make_req(cetvs_pkg::CMD_ALLOC, 32'd4, 32'd2, 0, 0, 32'd1, 0, 9'd0));
    send_request(make_req(cetvs_pkg::CMD_ALLOC, 32'd4, 32'd3, 0, 0, 32'd1, 0, 9'd0));
    drain();

    // Random phases with different sizes and idle patterns.
    for (int ph = 0; ph < 6; ph++) begin
      write_size(sizes[ph]);
      cnt = (sizes[ph] == 0 || sizes[ph] > 512) ? 512 : sizes[ph];
      send_idle_pct = (ph < 2) ? 37 : (ph < 4) ? 46 : 0;
      recv_idle_pct = (ph < 2) ? 46 : (ph < 4) ? 37 : 0;
      if (ph == 4) begin
        start_hold <= 1;
        @(posedge clk_i);
        start_hold <= 0;
      end
      for (int n = 0; n < 192; n++) send_request(random_req(cnt));
      drain();
    end

    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
